// File: rtl/core/utf8s_pkg.sv
`default_nettype none

package utf8s_pkg;

    // replacement character U+FFFD in utf-8
    localparam logic [7:0] REP_BYTE0 = 8'hEF;
    localparam logic [7:0] REP_BYTE1 = 8'hBF;
    localparam logic [7:0] REP_BYTE2 = 8'hBD;

    // byte class boundaries
    localparam logic [7:0] CONT_LO  = 8'h80;
    localparam logic [7:0] CONT_HI  = 8'hBF;
    localparam logic [7:0] LEAD2_LO = 8'hC0;
    localparam logic [7:0] LEAD3_LO = 8'hE0;
    localparam logic [7:0] LEAD4_LO = 8'hF0;
    localparam logic [7:0] LEAD_END = 8'hFC;

    localparam int LIMIT_W  = 12;
    localparam int LENGTH_W = 13;

    // most words one input byte can produce: four data bytes plus the summary
    localparam int ITEM_SLOTS = 5;
    localparam int SLOT_CNT_W = $clog2(ITEM_SLOTS + 1);

    typedef struct packed {
        logic [7:0]          out_byte;
        logic                has_byte;
        logic                last;
        logic [LENGTH_W-1:0] line_length;
        logic                line_clean;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/core/utf8s_in_if.sv
`default_nettype none

interface utf8s_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       line_end;

    modport source (output valid, output in_byte, output line_end, input ready);
    modport sink (input valid, input in_byte, input line_end, output ready);
endinterface

`default_nettype wire

// File: rtl/core/utf8s_out_if.sv
`default_nettype none

interface utf8s_out_if;
    logic                           valid;
    logic                           ready;
    logic [7:0]                     out_byte;
    logic                           has_byte;
    logic                           last;
    logic [utf8s_pkg::LENGTH_W-1:0] line_length;
    logic                           line_clean;

    modport source (
        output valid, output out_byte, output has_byte, output last,
        output line_length, output line_clean, input ready
    );
    modport sink (
        input valid, input out_byte, input has_byte, input last,
        input line_length, input line_clean, output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/utf8_sanitize_replace.sv
// utf-8 line sanitizer: passes well-formed utf-8 through and turns broken
// sequences and stray bytes into the replacement character EF BF BD
// channels: in_ch takes one raw byte per word, line_end marks the last byte
// of a line; out_ch gives one output byte per word, and after the last byte
// of each line a summary word (has_byte 0, last 1) with line length and
// clean flag
// config: cfg_we/cfg_wdata write output_limit; write it only while idle
// latency: the words caused by an input byte appear on out_ch in the cycle
// after it is accepted; a multibyte character comes out when its last byte
// arrives
// throughput: one input byte per cycle while each byte yields at most one
// word and out_ch is ready; a byte that yields more words blocks input until
// the single-read result buffer drains, one word per cycle while out_ch is ready
// reset: limit returns to min(MAX_LINE-5, 4095), line state is cleared,
// the result buffer is emptied
// stall: a word held on out_ch stays stable until taken; input is accepted
// only when the buffer is empty or its last word leaves in the same cycle
`default_nettype none

module utf8_sanitize_replace #(
    parameter int MAX_LINE = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    utf8s_in_if.sink                           in_ch,
    utf8s_out_if.source                        out_ch,
    input  wire logic                          cfg_we,
    input  wire logic [utf8s_pkg::LIMIT_W-1:0] cfg_wdata
);

    localparam int LW = utf8s_pkg::LIMIT_W;
    localparam int NW = utf8s_pkg::LENGTH_W;
    localparam int NS = utf8s_pkg::ITEM_SLOTS;
    localparam int CW = utf8s_pkg::SLOT_CNT_W;
    localparam logic [LW-1:0] LIMIT_RESET =
        (MAX_LINE > 4100) ? {LW{1'b1}} : LW'(MAX_LINE - 5);

    // configuration
    logic [LW-1:0] limit_reg;

    // line state
    logic [7:0]    held_reg [3];
    logic [7:0]    held_next [3];
    logic [2:0]    exp_reg, exp_next;      // claimed length, 0 when no sequence open
    logic [1:0]    rcv_reg, rcv_next;      // bytes of the sequence held so far
    logic          bad_reg, bad_next;
    logic [NW-1:0] count_reg, count_next;
    logic          clean_reg, clean_next;
    logic          stopped_reg, stopped_next;

    // result buffer, slot 0 is on the output
    utf8s_pkg::result_t slot_reg [NS];
    utf8s_pkg::result_t slot_next [NS];
    logic [CW-1:0]      fill_reg, fill_next;

    logic          accept, pop;
    logic [7:0]    c;
    logic          is_cont;
    logic          seq_bad_now;
    logic [2:0]    rcv_inc;
    logic          rep;
    logic [2:0]    nb;                     // data bytes produced by this word
    logic [7:0]    bytes [4];
    logic [NW-1:0] len_line;
    logic          clean_line;

    assign pop    = out_ch.valid && out_ch.ready;
    assign accept = in_ch.valid && in_ch.ready;
    // take a new byte once the buffer runs empty in this cycle
    assign in_ch.ready = (fill_reg == CW'(0)) || ((fill_reg == CW'(1)) && out_ch.ready);

    assign out_ch.valid       = (fill_reg != CW'(0));
    assign out_ch.out_byte    = slot_reg[0].out_byte;
    assign out_ch.has_byte    = slot_reg[0].has_byte;
    assign out_ch.last        = slot_reg[0].last;
    assign out_ch.line_length = slot_reg[0].line_length;
    assign out_ch.line_clean  = slot_reg[0].line_clean;

    assign c       = in_ch.in_byte;
    assign is_cont = c inside {[utf8s_pkg::CONT_LO:utf8s_pkg::CONT_HI]};

    // decode one byte against the line state
    always_comb
    begin
        held_next    = held_reg;
        exp_next     = exp_reg;
        rcv_next     = rcv_reg;
        bad_next     = bad_reg;
        clean_next   = clean_reg;
        stopped_next = stopped_reg;
        seq_bad_now  = bad_reg | ~is_cont;
        rcv_inc      = {1'b0, rcv_reg} + 3'd1;
        rep          = 1'b0;
        nb           = 3'd0;
        for (int k = 0; k < 4; k++)
        begin
            bytes[k] = c;
        end

        if (!stopped_reg)
        begin
            if (exp_reg == 3'd0)
            begin
                // a character would start here: check the limit first
                if (count_reg >= {1'b0, limit_reg})
                begin
                    stopped_next = 1'b1;
                end
                else if (c < utf8s_pkg::CONT_LO)
                begin
                    nb = 3'd1;
                end
                else if (c >= utf8s_pkg::LEAD2_LO && c < utf8s_pkg::LEAD_END)
                begin
                    if (c < utf8s_pkg::LEAD3_LO)
                    begin
                        exp_next = 3'd2;
                    end
                    else if (c < utf8s_pkg::LEAD4_LO)
                    begin
                        exp_next = 3'd3;
                    end
                    else
                    begin
                        exp_next = 3'd4;
                    end
                    held_next[0] = c;
                    rcv_next     = 2'd1;
                    bad_next     = 1'b0;
                end
                else
                begin
                    // stray continuation or invalid lead
                    rep = 1'b1;
                end
            end
            else
            begin
                if (rcv_reg != 2'd3)
                begin
                    held_next[rcv_reg] = c;
                end
                rcv_next = rcv_inc[1:0];
                bad_next = seq_bad_now;
                if (rcv_inc >= exp_reg)
                begin
                    if (seq_bad_now)
                    begin
                        rep = 1'b1;
                    end
                    else
                    begin
                        nb       = rcv_inc;
                        bytes[0] = held_reg[0];
                        bytes[1] = (rcv_reg > 2'd1) ? held_reg[1] : c;
                        bytes[2] = (rcv_reg > 2'd2) ? held_reg[2] : c;
                    end
                    exp_next = 3'd0;
                    rcv_next = 2'd0;
                    bad_next = 1'b0;
                end
            end
        end

        // sequence cut off by the end of the line
        if (in_ch.line_end && !stopped_next && exp_next != 3'd0)
        begin
            rep = 1'b1;
        end

        if (rep)
        begin
            nb         = 3'd3;
            bytes[0]   = utf8s_pkg::REP_BYTE0;
            bytes[1]   = utf8s_pkg::REP_BYTE1;
            bytes[2]   = utf8s_pkg::REP_BYTE2;
            clean_next = 1'b0;
        end

        len_line   = count_reg + NW'(nb);
        clean_line = clean_next;
        count_next = len_line;

        // data words first, then the summary word at the end of a line
        for (int k = 0; k < NS; k++)
        begin
            slot_next[k] = '0;
            if (3'(k) < nb)
            begin
                slot_next[k].out_byte = bytes[k];
                slot_next[k].has_byte = 1'b1;
            end
            else if (3'(k) == nb)
            begin
                slot_next[k].last        = 1'b1;
                slot_next[k].line_length = len_line;
                slot_next[k].line_clean  = clean_line;
            end
        end
        fill_next = CW'(nb) + CW'(in_ch.line_end);

        // line state returns to its start values after the summary
        if (in_ch.line_end)
        begin
            exp_next     = 3'd0;
            rcv_next     = 2'd0;
            bad_next     = 1'b0;
            count_next   = '0;
            clean_next   = 1'b1;
            stopped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg     <= 3'd0;
            rcv_reg     <= 2'd0;
            bad_reg     <= 1'b0;
            count_reg   <= '0;
            clean_reg   <= 1'b1;
            stopped_reg <= 1'b0;
        end
        else if (accept)
        begin
            exp_reg     <= exp_next;
            rcv_reg     <= rcv_next;
            bad_reg     <= bad_next;
            count_reg   <= count_next;
            clean_reg   <= clean_next;
            stopped_reg <= stopped_next;
        end
    end

    // held bytes are only read after being written in the same sequence
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_reg <= held_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (accept)
        begin
            fill_reg <= fill_next;
        end
        else if (pop)
        begin
            fill_reg <= fill_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg <= slot_next;
        end
        else if (pop)
        begin
            for (int k = 0; k < NS - 1; k++)
            begin
                slot_reg[k] <= slot_reg[k + 1];
            end
        end
    end

endmodule

`default_nettype wire

// File: test/utf8_sanitize_replace_checker.sv
`default_nettype none

module utf8_sanitize_replace_checker #(
    parameter int MAX_LINE = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    utf8s_in_if                                in_ch,
    utf8s_out_if                               out_ch,
    input  wire logic                          cfg_we,
    input  wire logic [utf8s_pkg::LIMIT_W-1:0] cfg_wdata,
    output int                                 fails,
    output int                                 pending
);

    localparam int LW = utf8s_pkg::LIMIT_W;
    localparam int NW = utf8s_pkg::LENGTH_W;
    localparam logic [LW-1:0] LIMIT_AT_RESET =
        (MAX_LINE > 4100) ? LW'(4095) : LW'(MAX_LINE - 5);

    // predicted sanitizer state
    logic [LW-1:0]  limit_reg;
    logic [7:0]     lead_buf [3];
    logic [2:0]     seq_need;
    logic [2:0]     seq_seen;
    logic           seq_broken;
    logic [NW-1:0]  written;
    logic           no_repl;
    logic           line_dropped;

    utf8s_pkg::result_t expected_words [$];
    int                 word_no;

    initial fails = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        fails++;
    endtask

    task automatic clear_line();
        lead_buf[0] = '0;
        lead_buf[1] = '0;
        lead_buf[2] = '0;
        seq_need = '0;
        seq_seen = '0;
        seq_broken = 1'b0;
        written = '0;
        no_repl = 1'b1;
        line_dropped = 1'b0;
    endtask

    task automatic push_byte(input logic [7:0] b);
        utf8s_pkg::result_t w;
        w = '0;
        w.out_byte = b;
        w.has_byte = 1'b1;
        expected_words.push_back(w);
        written = written + 1'b1;
    endtask

    task automatic push_fffd();
        push_byte(utf8s_pkg::REP_BYTE0);
        push_byte(utf8s_pkg::REP_BYTE1);
        push_byte(utf8s_pkg::REP_BYTE2);
        no_repl = 1'b0;
    endtask

    // expected words for one accepted input byte
    task automatic sanitize_byte(input logic [7:0] c, input logic eol);
        utf8s_pkg::result_t summary;
        int k;
        if (!line_dropped)
        begin
            if (seq_need == 0)
            begin
                if (written >= {1'b0, limit_reg})
                    line_dropped = 1'b1;
                else if (c < utf8s_pkg::CONT_LO)
                    push_byte(c);
                else if (c >= utf8s_pkg::LEAD2_LO && c < utf8s_pkg::LEAD_END)
                begin
                    seq_need = (c < utf8s_pkg::LEAD3_LO) ? 3'd2 :
                               (c < utf8s_pkg::LEAD4_LO) ? 3'd3 : 3'd4;
                    lead_buf[0] = c;
                    seq_seen = 3'd1;
                    seq_broken = 1'b0;
                end
                else
                    push_fffd();
            end
            else
            begin
                if (c < utf8s_pkg::CONT_LO || c > utf8s_pkg::CONT_HI)
                    seq_broken = 1'b1;
                if (seq_seen < 3)
                    lead_buf[seq_seen] = c;
                seq_seen = seq_seen + 1'b1;
                if (seq_seen >= seq_need)
                begin
                    if (seq_broken)
                        push_fffd();
                    else
                    begin
                        for (k = 0; k < ((seq_seen < 3) ? seq_seen : 3); k++)
                            push_byte(lead_buf[k]);
                        if (seq_seen > 3)
                            push_byte(c);
                    end
                    seq_need = '0;
                    seq_seen = '0;
                    seq_broken = 1'b0;
                end
            end
        end
        if (eol)
        begin
            // open sequence cut off by the end of the line
            if (!line_dropped && seq_need != 0)
                push_fffd();
            summary = '0;
            summary.last = 1'b1;
            summary.line_length = written;
            summary.line_clean = no_repl;
            expected_words.push_back(summary);
            clear_line();
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("word %0d %s: got 'h%0h, expected 'h%0h",
                                      word_no, name, got, want));
    endtask

    task automatic check_word();
        utf8s_pkg::result_t want;
        if (expected_words.size() == 0)
        begin
            report_mismatch($sformatf("word with none expected: byte 'h%0h has_byte %b last %b",
                                      out_ch.out_byte, out_ch.has_byte, out_ch.last));
            return;
        end
        want = expected_words.pop_front();
        compare_field("out_byte", 32'(out_ch.out_byte), 32'(want.out_byte));
        compare_field("has_byte", 32'(out_ch.has_byte), 32'(want.has_byte));
        compare_field("last", 32'(out_ch.last), 32'(want.last));
        compare_field("line_length", 32'(out_ch.line_length), 32'(want.line_length));
        compare_field("line_clean", 32'(out_ch.line_clean), 32'(want.line_clean));
        word_no++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg = LIMIT_AT_RESET;
            clear_line();
            expected_words.delete();
            word_no = 0;
        end
        else
        begin
            // output first: a word leaving now never comes from the byte taken now
            if (out_ch.valid && out_ch.ready)
                check_word();
            if (in_ch.valid && in_ch.ready)
                sanitize_byte(in_ch.in_byte, in_ch.line_end);
            if (cfg_we)
                limit_reg = cfg_wdata;
        end
        pending = expected_words.size();
    end

endmodule

`default_nettype wire

// File: test/utf8_sanitize_replace_test.sv
`default_nettype none

module utf8_sanitize_replace_test;

    localparam int MAX_LINE = 4096;
    localparam int LW = utf8s_pkg::LIMIT_W;
    // longest correct span with no word moving: the longest sender gap or
    // receiver stall, a drain pause plus the config write, the end wait;
    // the limit is set far above all of these
    localparam int IDLE_LIMIT = 1000;
    // random part stops after about this many input words
    localparam int RANDOM_WORDS = 200;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          cfg_we;
    logic [LW-1:0] cfg_wdata;
    int            fails;
    int            pending;

    utf8s_in_if  in_ch ();
    utf8s_out_if out_ch ();

    utf8_sanitize_replace #(
        .MAX_LINE (MAX_LINE)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // watches both channels and the config port, predicts and compares
    utf8_sanitize_replace_checker #(
        .MAX_LINE (MAX_LINE)
    ) line_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fails     (fails),
        .pending   (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // gap length: mostly short, now and then long
    function automatic int gap_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver: random stalls, with periodic stall-free stretches
    int sink_hold = 0;
    int cycle_no = 0;

    always @(posedge clk)
    begin
        cycle_no++;
        if (sink_hold > 0)
        begin
            sink_hold--;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            if ((cycle_no % 600) >= 150 && $urandom_range(0, 5) == 0)
                sink_hold = gap_len();
        end
    end

    // watchdog: cycles in a row in which no word moves on either channel
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("utf8_sanitize_replace_test: FAIL");
                $finish;
            end
        end
    end

    // sender side
    bit         src_calm = 1'b0;
    int         words_sent = 0;
    logic [7:0] line_buf [$];

    // one input word; valid stays high afterwards unless the next call lowers it
    task automatic send_word(input logic [7:0] b, input logic eol);
        int gap;
        gap = 0;
        if (!src_calm && $urandom_range(0, 3) == 0)
            gap = gap_len();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.line_end <= eol;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        words_sent++;
    endtask

    // send the bytes gathered in line_buf, line_end on the final one
    task automatic send_line();
        int i;
        for (i = 0; i < line_buf.size(); i++)
            send_word(line_buf[i], i == line_buf.size() - 1);
        line_buf.delete();
    endtask

    // hold off until every expected word has come, then let the block settle;
    // pending is read at the falling edge, away from the checker's updates
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_limit(input logic [LW-1:0] v);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] lead_for(input int n);
        case (n)
            2:       return 8'($urandom_range(8'hC0, 8'hDF));
            3:       return 8'($urandom_range(8'hE0, 8'hEF));
            default: return 8'($urandom_range(8'hF0, 8'hFB));
        endcase
    endfunction

    task automatic add_follower();
        line_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
    endtask

    // one random character: mostly well formed, some broken, some noise
    task automatic add_char();
        int r;
        int n;
        int k;
        r = $urandom_range(0, 99);
        if (r < 40)
            line_buf.push_back(8'($urandom_range(0, 8'h7F)));
        else if (r < 72)
        begin
            n = (r < 52) ? 2 : (r < 62) ? 3 : 4;
            line_buf.push_back(lead_for(n));
            repeat (n - 1) add_follower();
        end
        else if (r < 78)
        begin
            // stray byte: continuation or fc-ff
            if ($urandom_range(0, 1) == 0)
                line_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
            else
                line_buf.push_back(8'($urandom_range(8'hFC, 8'hFF)));
        end
        else if (r < 90)
        begin
            // bad follower somewhere inside the claimed sequence
            n = $urandom_range(2, 4);
            line_buf.push_back(lead_for(n));
            k = $urandom_range(0, n - 2);
            repeat (k) add_follower();
            if ($urandom_range(0, 1) == 0)
                line_buf.push_back(8'($urandom_range(0, 8'h7F)));
            else
                line_buf.push_back(8'($urandom_range(8'hC0, 8'hFF)));
            repeat (n - 2 - k) line_buf.push_back(8'($urandom_range(0, 255)));
        end
        else
            line_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    // a sequence left open for the end of the line
    task automatic add_cut_tail();
        int n;
        n = $urandom_range(2, 4);
        line_buf.push_back(lead_for(n));
        repeat ($urandom_range(0, n - 2)) add_follower();
    endtask

    initial
    begin
        int random_start;
        int phase_no;
        int r;
        int chars;
        logic [LW-1:0] lim;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.in_byte = '0;
        in_ch.line_end = 1'b0;
        out_ch.ready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed, limit at its reset value
        // well-formed ascii extremes and 2, 3, 4 byte characters
        line_buf = '{8'h00, 8'h7F, 8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC,
                     8'hF0, 8'h9F, 8'h98, 8'h80};
        send_line();
        // stray bytes, bad second follower, bad third follower, cut at line end
        line_buf = '{8'h80, 8'hFF, 8'hFC, 8'hC3, 8'h41, 8'hE0, 8'h80, 8'hC0, 8'hF8};
        send_line();
        // highest 4-byte lead, line ends on its last follower
        line_buf = '{8'hFB, 8'h80, 8'h80, 8'hBF};
        send_line();
        // one-byte line
        line_buf = '{8'h41};
        send_line();

        // limit reached by a started character, line runs past the limit
        src_calm = 1'b1;
        set_limit(LW'(10));
        repeat (8) line_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
        line_buf.push_back(8'hF0);
        line_buf.push_back(8'h9F);
        line_buf.push_back(8'h98);
        line_buf.push_back(8'h80);
        line_buf.push_back(8'h41);
        line_buf.push_back(8'hC2);
        line_buf.push_back(8'hA9);
        send_line();
        src_calm = 1'b0;

        // limit lowered mid-line at a character boundary
        send_word(8'h41, 1'b0);
        send_word(8'h42, 1'b0);
        set_limit(LW'(3));
        line_buf = '{8'h43, 8'h44, 8'hE2, 8'h82, 8'hAC};
        send_line();

        // zero limit: summary word only
        set_limit('0);
        line_buf = '{8'h41, 8'hC2, 8'hA9, 8'h80};
        send_line();

        // random phases, each with its own limit
        random_start = words_sent;
        phase_no = 0;
        while (words_sent - random_start < RANDOM_WORDS)
        begin
            r = $urandom_range(0, 99);
            if (phase_no == 0)
                lim = '0;
            else if (phase_no == 1)
                lim = LW'(4095);
            else if (r < 60)
                lim = LW'($urandom_range(1, 24));
            else if (r < 70)
                lim = '0;
            else if (r < 80)
                lim = LW'(4095);
            else
                lim = LW'($urandom_range(0, 4095));
            set_limit(lim);
            src_calm = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(2, 5))
            begin
                chars = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 10);
                repeat (chars) add_char();
                if ($urandom_range(0, 7) == 0)
                    add_cut_tail();
                send_line();
                // now and then the sender waits for every expected word
                if ($urandom_range(0, 5) == 0)
                    wait_drained();
            end
            phase_no++;
        end

        // drain, then wait on for anything stray
        in_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (10) @(posedge clk);
        @(negedge clk);
        if (fails == 0)
            $display("utf8_sanitize_replace_test: PASS");
        else
            $display("utf8_sanitize_replace_test: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
